/* sv/dual_pid_force_controller_assert.svh */
// assertion macros for the dual pid force controller
// expects signals clk and rst in the scope where a macro is used
`ifndef DUAL_PID_FORCE_CONTROLLER_ASSERT_SVH
`define DUAL_PID_FORCE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define DPFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpfc same-cycle check failed");

// antecedent implies consequent in the next cycle
`define DPFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpfc next-cycle check failed");

`else

`define DPFC_ASSERT_SAME(label, ante, cons)
`define DPFC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/dpfc_pkg.sv */
// shared types and constants of the dual pid force controller
// no dependencies
package dpfc_pkg;

  localparam int DATA_W  = 32;
  localparam int TS_W    = 24;
  localparam int INTEG_W = 48;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 67;

  localparam logic [TS_W-1:0] TIME_STEP_RESET = 24'd16777;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KP_POS,
    CFG_KI_POS,
    CFG_KD_POS,
    CFG_KP_ANG,
    CFG_KI_ANG,
    CFG_KD_ANG,
    CFG_TARGET_ANGLE,
    CFG_TIME_STEP
  } cfg_reg_t;

  // one multiplier pass per code, issued in this order
  typedef enum logic [3:0] {
    SEL_IPOS,
    SEL_IANG,
    SEL_KP_POS,
    SEL_KD_POS,
    SEL_KP_ANG,
    SEL_KD_ANG,
    SEL_KI_POS_LO,
    SEL_KI_POS_HI,
    SEL_KI_ANG_LO,
    SEL_KI_ANG_HI
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  accept;
    logic  busy;
    logic  mul_en;
    step_t step;
    logic  load_out;
  } ctrl_t;

endpackage

/* sv/dpfc_mul.sv */
// shared signed 33x33 multiplier with registered product and step tag
// depends on dpfc_pkg
module dpfc_mul import dpfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  step_t                    tag,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic                     prod_valid,
  output step_t                    prod_tag,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= en;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= op_a * op_b;
      prod_tag <= tag;
    end
  end

endmodule

/* sv/dpfc_ctrl.sv */
// sequencer that walks the shared multiplier through the ten passes
// depends on dpfc_pkg
module dpfc_ctrl import dpfc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_hold,
  output ctrl_t ctl
);

  state_t state, state_next;
  step_t  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= SEL_IPOS;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        step_next = SEL_IPOS;
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step == SEL_KI_ANG_HI) begin
          state_next = ST_FLUSH;
        end else begin
          step_next = step_t'(step + 4'd1);
        end
      end
      ST_FLUSH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_hold) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.accept   = 1'b0;
    ctl.busy     = 1'b1;
    ctl.mul_en   = 1'b0;
    ctl.step     = step;
    ctl.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctl.busy   = 1'b0;
        ctl.accept = in_valid;
      end
      ST_RUN: begin
        ctl.mul_en = 1'b1;
      end
      ST_FLUSH: begin
      end
      ST_DONE: begin
        ctl.load_out = !out_hold;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/dual_pid_force_controller.sv */
// Dual PID force controller, top level. Uses dpfc_pkg, dpfc_ctrl, dpfc_mul and the
// assertion macros. One transaction on the input side yields one force value: the
// position error and angle error are saturated to 32 bits, both error integrals advance
// by the trapezoidal rule with the time step, and six gain products (rounded half up,
// Q16.16) are summed exactly and saturated to 32 bits. All products go through a single
// registered 33x33 multiplier, ten passes per transaction (the 48-bit integral products
// take two passes each). An accepted transaction runs the ten multiplier passes,
// waits in a flush state for the last accumulate and then moves the force into the
// output register; a result left waiting in the output register does not stop the
// next transaction from being accepted, only from finishing.
module dual_pid_force_controller import dpfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] cart_position,
  input  logic signed [DATA_W-1:0] cart_velocity,
  input  logic signed [DATA_W-1:0] pendulum_angle,
  input  logic signed [DATA_W-1:0] pendulum_rate,
  input  logic signed [DATA_W-1:0] target_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] force_res
);

  `include "dual_pid_force_controller_assert.svh"

  logic signed [DATA_W-1:0]  kp_pos, ki_pos, kd_pos, kp_ang, ki_ang, kd_ang, target_angle;
  logic        [TS_W-1:0]    time_step;

  logic signed [DATA_W-1:0]  e_pos, e_ang, vel, rate;
  logic signed [DATA_W-1:0]  e_pos_next, e_ang_next;
  logic signed [DATA_W-1:0]  last_pe, last_ae;
  logic signed [INTEG_W-1:0] pos_integ, ang_integ;
  logic signed [ACC_W-1:0]   acc, acc_next, acc_add;
  logic                      acc_cin;

  ctrl_t                     ctl;
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic                      mul_valid;
  step_t                     mul_tag;
  logic signed [PROD_W-1:0]  prod;

  logic signed [MUL_W-1:0]   inc;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sel, integ_next;
  logic signed [DATA_W-1:0]  force_next;

  // exact difference, clamped to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) begin
      sub_sat = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sub_sat = d[DATA_W-1:0];
    end
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_pos       <= '0;
      ki_pos       <= '0;
      kd_pos       <= '0;
      kp_ang       <= '0;
      ki_ang       <= '0;
      kd_ang       <= '0;
      target_angle <= '0;
      time_step    <= TIME_STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KP_POS:       kp_pos       <= cfg_data;
        CFG_KI_POS:       ki_pos       <= cfg_data;
        CFG_KD_POS:       kd_pos       <= cfg_data;
        CFG_KP_ANG:       kp_ang       <= cfg_data;
        CFG_KI_ANG:       ki_ang       <= cfg_data;
        CFG_KD_ANG:       kd_ang       <= cfg_data;
        CFG_TARGET_ANGLE: target_angle <= cfg_data;
        CFG_TIME_STEP:    time_step    <= cfg_data[TS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dpfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_hold (out_valid && out_stall),
    .ctl      (ctl)
  );

  assign in_stall = ctl.busy;

  assign e_pos_next = sub_sat(cart_position, target_position);
  assign e_ang_next = sub_sat(pendulum_angle, target_angle);

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      e_pos <= e_pos_next;
      e_ang <= e_ang_next;
      vel   <= cart_velocity;
      rate  <= pendulum_rate;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctl.step)
      SEL_IPOS: begin
        op_a = {last_pe[DATA_W-1], last_pe} + {e_pos[DATA_W-1], e_pos};
        op_b = {{(MUL_W-TS_W){1'b0}}, time_step};
      end
      SEL_IANG: begin
        op_a = {last_ae[DATA_W-1], last_ae} + {e_ang[DATA_W-1], e_ang};
        op_b = {{(MUL_W-TS_W){1'b0}}, time_step};
      end
      SEL_KP_POS: begin
        op_a = {e_pos[DATA_W-1], e_pos};
        op_b = {kp_pos[DATA_W-1], kp_pos};
      end
      SEL_KD_POS: begin
        op_a = {vel[DATA_W-1], vel};
        op_b = {kd_pos[DATA_W-1], kd_pos};
      end
      SEL_KP_ANG: begin
        op_a = {e_ang[DATA_W-1], e_ang};
        op_b = {kp_ang[DATA_W-1], kp_ang};
      end
      SEL_KD_ANG: begin
        op_a = {rate[DATA_W-1], rate};
        op_b = {kd_ang[DATA_W-1], kd_ang};
      end
      SEL_KI_POS_LO: begin
        op_a = {{(MUL_W-16){1'b0}}, pos_integ[15:0]};
        op_b = {ki_pos[DATA_W-1], ki_pos};
      end
      SEL_KI_POS_HI: begin
        op_a = {pos_integ[INTEG_W-1], pos_integ[INTEG_W-1:16]};
        op_b = {ki_pos[DATA_W-1], ki_pos};
      end
      SEL_KI_ANG_LO: begin
        op_a = {{(MUL_W-16){1'b0}}, ang_integ[15:0]};
        op_b = {ki_ang[DATA_W-1], ki_ang};
      end
      SEL_KI_ANG_HI: begin
        op_a = {ang_integ[INTEG_W-1], ang_integ[INTEG_W-1:16]};
        op_b = {ki_ang[DATA_W-1], ki_ang};
      end
      default: begin
      end
    endcase
  end

  dpfc_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .en         (ctl.mul_en),
    .tag        (ctl.step),
    .op_a       (op_a),
    .op_b       (op_b),
    .prod_valid (mul_valid),
    .prod_tag   (mul_tag),
    .prod       (prod)
  );

  // integral step: product is Q16.40, halve and return to Q16.16 with round half up
  assign inc        = prod[MUL_W+24:25];
  assign integ_sel  = (mul_tag == SEL_IPOS) ? pos_integ : ang_integ;
  assign integ_sum  = {integ_sel[INTEG_W-1], integ_sel}
                    + {{(INTEG_W+1-MUL_W){inc[MUL_W-1]}}, inc}
                    + {{INTEG_W{1'b0}}, prod[24]};

  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_next = integ_sum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_integ <= '0;
      ang_integ <= '0;
      last_pe   <= '0;
      last_ae   <= '0;
    end else if (mul_valid) begin
      if (mul_tag == SEL_IPOS) begin
        pos_integ <= integ_next;
        last_pe   <= e_pos;
      end
      if (mul_tag == SEL_IANG) begin
        ang_integ <= integ_next;
        last_ae   <= e_ang;
      end
    end
  end

  // force accumulator: high halves of integral products enter unshifted, integral step
  // products not at all, all others as (p >>> 16) with bit 15 as the rounding carry
  always_comb begin
    acc_add = '0;
    acc_cin = 1'b0;
    case (mul_tag) inside
      SEL_IPOS, SEL_IANG: begin
      end
      SEL_KI_POS_HI, SEL_KI_ANG_HI: begin
        acc_add = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      end
      default: begin
        acc_add = {{(ACC_W-PROD_W+16){prod[PROD_W-1]}}, prod[PROD_W-1:16]};
        acc_cin = prod[15];
      end
    endcase
  end

  assign acc_next = acc + acc_add + {{(ACC_W-1){1'b0}}, acc_cin};

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      acc <= '0;
    end else if (mul_valid) begin
      acc <= acc_next;
    end
  end

  always_comb begin
    if (acc[ACC_W-1:DATA_W-1] == '0 || acc[ACC_W-1:DATA_W-1] == '1) begin
      force_next = acc[DATA_W-1:0];
    end else if (acc[ACC_W-1]) begin
      force_next = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      force_next = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      force_res <= force_next;
    end
  end

  `DPFC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `DPFC_ASSERT_NEXT(a_acc_cleared, in_valid && !in_stall, acc == '0)
  `DPFC_ASSERT_SAME(a_mul_only_when_busy, mul_valid, in_stall)
  `DPFC_ASSERT_SAME(a_load_not_over_waiting, ctl.load_out, !(out_valid && out_stall))

endmodule
